// ----- rtl/bfcrc_pkg.sv -----
// Shared types and constants of the bus frame CRC-8 framer.
`default_nettype none

package bfcrc_pkg;

    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    // Frame layouts; the fourth code acts as slave receive.
    localparam logic [MODE_W-1:0] MODE_MASTER_TX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLAVE_TX  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLAVE_RX  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 1'd1;

    localparam logic [BYTE_W-1:0] CRC_POLY_RESET = 8'hD5;
    localparam logic [BYTE_W-1:0] MSB_MASK       = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [BYTE_W-1:0] crc_value;
        logic              is_check_slot;
        logic              frame_end;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/bfcrc_crc8.sv -----
// MSB-first augmented CRC-8 update over one byte.
`default_nettype none

module bfcrc_crc8
    import bfcrc_pkg::*;
(
    input  wire logic [BYTE_W-1:0] crc_in,
    input  wire logic [BYTE_W-1:0] data,
    input  wire logic [BYTE_W-1:0] poly,
    output logic      [BYTE_W-1:0] crc_out
);

    always_comb
    begin
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] din;
        logic              top;
        crc = crc_in;
        din = data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            top = |(crc & MSB_MASK);
            crc = {crc[BYTE_W-2:0], |(din & MSB_MASK)};
            din = {din[BYTE_W-2:0], 1'b0};
            if (top)
            begin
                crc = crc ^ poly;
            end
        end
        crc_out = crc;
    end

endmodule

`default_nettype wire

// ----- rtl/bfcrc_framer_ctl.sv -----
// Frame state (header phase, byte count, CRC) and per-item result logic.
`default_nettype none

module bfcrc_framer_ctl
    import bfcrc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              frame_start,
    input  wire logic [MODE_W-1:0] frame_mode,
    input  wire logic [BYTE_W-1:0] crc_poly,
    output result_t                result
);

    logic [BYTE_W-1:0] crc_reg, crc_next;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] remaining_reg, remaining_next;
    logic [BYTE_W-1:0] shift_data;
    logic [BYTE_W-1:0] crc_shifted;
    logic              more_body;

    assign more_body  = remaining_reg > 8'd1;
    // Payload bytes feed the CRC; the check slot flushes with zeros.
    assign shift_data = more_body ? data_byte : '0;

    bfcrc_crc8 u_crc8 (
        .crc_in  (crc_reg),
        .data    (shift_data),
        .poly    (crc_poly),
        .crc_out (crc_shifted)
    );

    always_comb
    begin
        logic take_header;
        crc_next       = crc_reg;
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        result         = '{out_byte: data_byte, crc_value: '0,
                           is_check_slot: 1'b0, frame_end: 1'b0};
        take_header    = frame_start;
        case (phase_reg)
            PH_HEADER: take_header = 1'b1;
            PH_LENGTH: ;
            PH_BODY:   ;
            default:   take_header = 1'b1;
        endcase

        if (take_header || phase_reg == PH_LENGTH)
        begin
            if (take_header)
            begin
                crc_next = '0;
            end
            if (take_header && frame_mode == MODE_MASTER_TX)
            begin
                phase_next     = PH_LENGTH;
                remaining_next = '0;
            end
            else
            begin
                // Length byte: zero length closes the frame at once.
                remaining_next = data_byte;
                if (data_byte == '0)
                begin
                    phase_next       = PH_HEADER;
                    result.frame_end = 1'b1;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
        end
        else if (more_body)
        begin
            crc_next       = crc_shifted;
            remaining_next = remaining_reg - 8'd1;
        end
        else
        begin
            crc_next             = crc_shifted;
            result.crc_value     = crc_shifted;
            result.is_check_slot = 1'b1;
            result.frame_end     = 1'b1;
            if (frame_mode == MODE_MASTER_TX || frame_mode == MODE_SLAVE_TX)
            begin
                result.out_byte = crc_shifted;
            end
            remaining_next = '0;
            phase_next     = PH_HEADER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            phase_reg     <= PH_HEADER;
            remaining_reg <= '0;
        end
        else if (advance)
        begin
            crc_reg       <= crc_next;
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bus_frame_crc8_framer_unit.sv -----
// Top level of the bus frame CRC-8 framer: input stage, frame logic, output stage.
`default_nettype none

// Byte framer for a two-wire bus link. Each input item is one frame byte with
// a frame_start flag in s_tuser; each item yields exactly one result item.
// Master transmit frames are address, length, body; slave frames are length,
// body. The length counts payload bytes plus the closing check byte. The CRC
// (MSB-first, augmented, polynomial from register 1, reset 0xD5) starts at
// zero per frame, covers the payload only and is flushed with eight zero bits
// on the check slot. In the transmit modes the check slot carries the CRC; in
// slave receive the byte passes through and the CRC is reported in
// m_tdata[15:8], with no comparison. m_tuser flags the check slot, m_tlast the
// last byte of a frame. Throughput is one item per clock unless m_tready
// stalls the output. The input register captures an accepted item, then the
// result register takes its result and raises m_tvalid; the CRC update is
// combinational. The user must write configuration through cfg_* while the
// block is idle; the block does not enforce this. cfg_ready is always high.

module bus_frame_crc8_framer_unit
    import bfcrc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,  // [7:0] data_byte
    input  wire logic                 s_tuser,  // [0] frame_start
    // output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,  // [7:0] out_byte, [15:8] crc_value
    output logic                      m_tuser,  // [0] is_check_slot
    output logic                      m_tlast   // frame_end
);

    // Configuration registers.
    logic [MODE_W-1:0] mode_reg;
    logic [BYTE_W-1:0] poly_reg;

    // Input stage.
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_start_reg;

    // Result stage.
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;
    result_t           res;

    logic s_accept;
    logic m_accept;
    logic out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MASTER_TX;
            poly_reg <= CRC_POLY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                CFG_CRC_POLY:   poly_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Move the held item into the result register whenever that register
    // is empty or being drained this cycle; the frame state advances with it.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_valid_reg && m_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_accept ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on load, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    bfcrc_framer_ctl u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (out_load),
        .data_byte   (in_data_reg),
        .frame_start (in_start_reg),
        .frame_mode  (mode_reg),
        .crc_poly    (poly_reg),
        .result      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.crc_value, out_res_reg.out_byte};
    assign m_tuser  = out_res_reg.is_check_slot;
    assign m_tlast  = out_res_reg.frame_end;

    // A check slot always closes its frame.
    a_check_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("check slot without frame end");

    // The CRC field is zero away from the check slot.
    a_crc_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[15:8] == 8'd0)
        else $error("crc value outside check slot");

    // Input backpressure only when both stages are full.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with free stage");

    // A stalled result is loaded over only when it is taken.
    a_load_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_valid_reg |-> m_tready)
        else $error("result overwritten before delivery");

endmodule

`default_nettype wire
